### sv/ett_pkg.sv
// ett_pkg: shared constants, command codes and types of the eased tween timeline.
// Used by ett_alu, ett_seq, eased_tween_timeline and ett_checker; depends on nothing.
`default_nettype none

package ett_pkg;

  // default sizes, used as the defaults of the top level parameters
  localparam int TIME_BITS_DEF     = 24;
  localparam int VALUE_BITS_DEF    = 32;
  localparam int FRACTION_BITS_DEF = 16;

  // fixed field widths
  localparam int TICK_BITS      = 16;
  localparam int COUNT_BITS     = 16;
  localparam int OPCODE_BITS    = 3;
  localparam int CURVE_BITS     = 3;
  localparam int CFG_INDEX_BITS = 3;

  // commands
  localparam logic [OPCODE_BITS-1:0] OP_TICK     = 3'd0;
  localparam logic [OPCODE_BITS-1:0] OP_START    = 3'd1;
  localparam logic [OPCODE_BITS-1:0] OP_FINISH   = 3'd2;
  localparam logic [OPCODE_BITS-1:0] OP_COMPLETE = 3'd3;
  localparam logic [OPCODE_BITS-1:0] OP_CANCEL   = 3'd4;

  // easing curves; any other code is linear
  localparam logic [CURVE_BITS-1:0] CURVE_QUAD_IN  = 3'd1;
  localparam logic [CURVE_BITS-1:0] CURVE_QUAD_OUT = 3'd2;
  localparam logic [CURVE_BITS-1:0] CURVE_SMOOTH_A = 3'd3;
  localparam logic [CURVE_BITS-1:0] CURVE_SMOOTH_B = 3'd4;

  // configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_CURVE    = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DELAY    = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DURATION = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_REPEAT   = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_START    = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_END      = 3'd5;

  // shared unit operations
  localparam logic [2:0] ALU_NOP        = 3'd0;
  localparam logic [2:0] ALU_LOAD_DIV   = 3'd1;
  localparam logic [2:0] ALU_DIV_STEP   = 3'd2;
  localparam logic [2:0] ALU_CLEAR      = 3'd3;
  localparam logic [2:0] ALU_BLEND_STEP = 3'd4;
  localparam logic [2:0] ALU_MUL        = 3'd5;

  typedef struct packed {
    logic [2:0] op;
    logic       bit_in;   // multiplier bit for a blend step
  } alu_cmd_t;

  // result flags, started in bit 0
  typedef struct packed {
    logic running;
    logic canceled;
    logic finished;
    logic started;
  } flags_t;

  function automatic int max2(int a, int b);
    return (a > b) ? a : b;
  endfunction

endpackage

`default_nettype wire

### sv/ett_alu.sv
// ett_alu: shared arithmetic unit: one wide adder for restoring division steps and
// serial blend steps, plus one registered multiplier for the easing curves. Uses ett_pkg.
`default_nettype none

module ett_alu #(
  parameter int TIME_BITS     = ett_pkg::TIME_BITS_DEF,
  parameter int VALUE_BITS    = ett_pkg::VALUE_BITS_DEF,
  parameter int FRACTION_BITS = ett_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                                   clk,
  input  wire ett_pkg::alu_cmd_t                      cmd,
  input  wire logic [TIME_BITS:0]                     div_num,
  input  wire logic [TIME_BITS-1:0]                   div_den,
  input  wire logic [VALUE_BITS:0]                    blend_d,
  input  wire logic [FRACTION_BITS+1:0]               mul_a,
  input  wire logic [FRACTION_BITS+1:0]               mul_b,
  output logic [ett_pkg::max2(VALUE_BITS+FRACTION_BITS+2, TIME_BITS+2)-1:0] acc_o,
  output logic [FRACTION_BITS-1:0]                    quo_o,
  output logic [2*FRACTION_BITS+3:0]                  prod_o
);

  localparam int ACC_W  = ett_pkg::max2(VALUE_BITS+FRACTION_BITS+2, TIME_BITS+2);
  localparam int PROD_W = 2*FRACTION_BITS+4;

  logic [ACC_W-1:0]         acc_r, acc_nxt;
  logic [ACC_W-1:0]         add_x, add_y, add_sum;
  logic                     add_cin;
  logic [FRACTION_BITS-1:0] quo_r, quo_nxt;
  logic [PROD_W-1:0]        prod_r, prod_nxt;

  // shared adder: acc*2 minus divisor, or acc*2 plus the blend difference
  always_comb begin
    add_x   = {acc_r[ACC_W-2:0], 1'b0};
    add_cin = 1'b0;
    if (cmd.op == ett_pkg::ALU_DIV_STEP) begin
      add_y   = ~{{(ACC_W-TIME_BITS){1'b0}}, div_den};
      add_cin = 1'b1;
    end else if (cmd.bit_in) begin
      add_y = {{(ACC_W-VALUE_BITS-1){blend_d[VALUE_BITS]}}, blend_d};
    end else begin
      add_y = '0;
    end
    add_sum = add_x + add_y + {{(ACC_W-1){1'b0}}, add_cin};
  end

  // operation select
  always_comb begin
    acc_nxt  = acc_r;
    quo_nxt  = quo_r;
    prod_nxt = prod_r;
    unique case (cmd.op)
      ett_pkg::ALU_LOAD_DIV: begin
        acc_nxt = {{(ACC_W-TIME_BITS-1){1'b0}}, div_num};
        quo_nxt = '0;
      end
      ett_pkg::ALU_DIV_STEP: begin
        // non-negative difference: subtract and shift in a one
        acc_nxt = add_sum[ACC_W-1] ? add_x : add_sum;
        quo_nxt = {quo_r[FRACTION_BITS-2:0], ~add_sum[ACC_W-1]};
      end
      ett_pkg::ALU_CLEAR:      acc_nxt = '0;
      ett_pkg::ALU_BLEND_STEP: acc_nxt = add_sum;
      ett_pkg::ALU_MUL:        prod_nxt = mul_a * mul_b;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    quo_r  <= quo_nxt;
    prod_r <= prod_nxt;
  end

  assign acc_o  = acc_r;
  assign quo_o  = quo_r;
  assign prod_o = prod_r;

endmodule

`default_nettype wire

### sv/ett_seq.sv
// ett_seq: sequencer with the configuration registers and channel state; it applies
// each command and steps ett_alu through division, easing and blend. Uses ett_pkg.
`default_nettype none

module ett_seq #(
  parameter int TIME_BITS     = ett_pkg::TIME_BITS_DEF,
  parameter int VALUE_BITS    = ett_pkg::VALUE_BITS_DEF,
  parameter int FRACTION_BITS = ett_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst_n,
  // command side
  input  wire logic                                      in_valid,
  output logic                                           in_ready,
  input  wire logic [ett_pkg::OPCODE_BITS-1:0]           in_opcode,
  input  wire logic [ett_pkg::TICK_BITS-1:0]             in_tick,
  // configuration
  input  wire logic                                      cfg_wr_en,
  input  wire logic [ett_pkg::CFG_INDEX_BITS-1:0]        cfg_index,
  input  wire logic [ett_pkg::max2(ett_pkg::max2(TIME_BITS, VALUE_BITS),
                                   ett_pkg::COUNT_BITS)-1:0] cfg_data,
  // result side
  output logic                                           res_valid,
  input  wire logic                                      res_ready,
  output logic [VALUE_BITS-1:0]                          res_value,
  output logic [FRACTION_BITS:0]                         res_frac,
  output ett_pkg::flags_t                                res_flags,
  // shared unit
  output ett_pkg::alu_cmd_t                              alu_cmd,
  output logic [TIME_BITS:0]                             alu_num,
  output logic [TIME_BITS-1:0]                           alu_den,
  output logic [VALUE_BITS:0]                            alu_d,
  output logic [FRACTION_BITS+1:0]                       alu_ma,
  output logic [FRACTION_BITS+1:0]                       alu_mb,
  input  wire logic [ett_pkg::max2(VALUE_BITS+FRACTION_BITS+2, TIME_BITS+2)-1:0] alu_acc,
  input  wire logic [FRACTION_BITS-1:0]                  alu_quo,
  input  wire logic [2*FRACTION_BITS+3:0]                alu_prod
);

  localparam int F     = FRACTION_BITS;
  localparam int CNT_W = $clog2(F+1);
  localparam int SUM_W = ett_pkg::max2(TIME_BITS+1, ett_pkg::TICK_BITS) + 1;

  localparam logic [F:0]           ONE     = {1'b1, {F{1'b0}}};
  localparam logic [F+1:0]         ONE_X3  = {2'b11, {F{1'b0}}};
  localparam logic [SUM_W-1:0]     EL_MAX  = {{(SUM_W-TIME_BITS-1){1'b0}}, {(TIME_BITS+1){1'b1}}};
  localparam logic [ett_pkg::COUNT_BITS-1:0] COUNT_MAX = '1;

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_UPD   = 4'd1;
  localparam logic [3:0] S_DSET  = 4'd2;
  localparam logic [3:0] S_DIV   = 4'd3;
  localparam logic [3:0] S_DEND  = 4'd4;
  localparam logic [3:0] S_EASE0 = 4'd5;
  localparam logic [3:0] S_EASE1 = 4'd6;
  localparam logic [3:0] S_EASE2 = 4'd7;
  localparam logic [3:0] S_BSET  = 4'd8;
  localparam logic [3:0] S_BLEND = 4'd9;
  localparam logic [3:0] S_BFIN  = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;

  // configuration registers
  logic [ett_pkg::CURVE_BITS-1:0] curve_r;
  logic [TIME_BITS-1:0]           delay_len_r, dur_r;
  logic [ett_pkg::COUNT_BITS-1:0] repeat_r;
  logic [VALUE_BITS-1:0]          start_r, end_r;

  // control and channel state
  logic [3:0]                     state_r, state_nxt;
  logic [CNT_W-1:0]               cnt_r, cnt_nxt;
  logic                           active_r, active_nxt;
  logic                           begun_r, begun_nxt;
  logic [TIME_BITS:0]             delay_el_r, delay_el_nxt;
  logic [TIME_BITS:0]             pass_r, pass_nxt;
  logic [ett_pkg::COUNT_BITS-1:0] passes_r, passes_nxt;
  logic [VALUE_BITS-1:0]          held_r, held_nxt;
  logic                           blend_r, blend_nxt;
  ett_pkg::flags_t                flags_r, flags_nxt;

  // payload
  logic [ett_pkg::OPCODE_BITS-1:0] op_r, op_nxt;
  logic [ett_pkg::TICK_BITS-1:0]   dt_r, dt_nxt;
  logic [F:0]                      t_r, t_nxt;
  logic [F:0]                      s_r, s_nxt;

  // time arithmetic for the command update
  logic [SUM_W-1:0]               delay_sum, pass_sum, wrap_sum;
  logic [TIME_BITS:0]             delay_sat, pass_clamp, wrap_sat, pass_left;
  logic [ett_pkg::COUNT_BITS-1:0] passes_inc;
  logic                           repeat_more;
  logic                           curve_sq, curve_smooth;
  logic [F:0]                     sq_hi;

  always_comb begin
    pass_left  = pass_r - {1'b0, dur_r};
    delay_sum  = SUM_W'(delay_el_r) + SUM_W'(dt_r);
    pass_sum   = SUM_W'(pass_r) + SUM_W'(dt_r);
    wrap_sum   = SUM_W'(pass_left) + SUM_W'(dt_r);
    delay_sat  = (delay_sum > EL_MAX) ? '1 : delay_sum[TIME_BITS:0];
    wrap_sat   = (wrap_sum > EL_MAX) ? '1 : wrap_sum[TIME_BITS:0];
    pass_clamp = (pass_sum > SUM_W'(dur_r)) ? {1'b0, dur_r} : pass_sum[TIME_BITS:0];
    passes_inc = (passes_r != COUNT_MAX) ? passes_r + 1'b1 : passes_r;
    repeat_more = (repeat_r == '0) || (passes_inc < repeat_r);
  end

  // curve decode and product high part
  assign curve_smooth = (curve_r == ett_pkg::CURVE_SMOOTH_A) ||
                        (curve_r == ett_pkg::CURVE_SMOOTH_B);
  assign curve_sq     = (curve_r == ett_pkg::CURVE_QUAD_IN) || curve_smooth;
  assign sq_hi        = alu_prod[2*F:F];

  // shared unit operands that do not depend on the step
  assign alu_num = pass_r;
  assign alu_den = dur_r;
  assign alu_d   = {end_r[VALUE_BITS-1], end_r} - {start_r[VALUE_BITS-1], start_r};

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    active_nxt   = active_r;
    begun_nxt    = begun_r;
    delay_el_nxt = delay_el_r;
    pass_nxt     = pass_r;
    passes_nxt   = passes_r;
    held_nxt     = held_r;
    blend_nxt    = blend_r;
    flags_nxt    = flags_r;
    op_nxt       = op_r;
    dt_nxt       = dt_r;
    t_nxt        = t_r;
    s_nxt        = s_r;
    alu_cmd      = '{op: ett_pkg::ALU_NOP, bit_in: 1'b0};
    alu_ma       = '0;
    alu_mb       = '0;
    in_ready     = 1'b0;
    res_valid    = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_nxt    = in_opcode;
          dt_nxt    = in_tick;
          state_nxt = S_UPD;
        end
      end

      // apply the command to the channel state
      S_UPD: begin
        blend_nxt = 1'b0;
        flags_nxt = '0;
        if (op_r == ett_pkg::OP_START) begin
          active_nxt   = 1'b1;
          begun_nxt    = 1'b0;
          delay_el_nxt = '0;
          pass_nxt     = '0;
          passes_nxt   = '0;
        end else if (active_r) begin
          unique case (op_r)
            ett_pkg::OP_TICK: begin
              if (delay_el_r < {1'b0, delay_len_r}) begin
                delay_el_nxt = delay_sat;
              end else begin
                if (!begun_r) begin
                  begun_nxt         = 1'b1;
                  flags_nxt.started = 1'b1;
                end
                if (pass_r < {1'b0, dur_r}) begin
                  pass_nxt  = pass_clamp;
                  blend_nxt = 1'b1;
                end else begin
                  // pass ended: repeat carrying the overshoot, or stop
                  held_nxt           = end_r;
                  passes_nxt         = passes_inc;
                  flags_nxt.finished = 1'b1;
                  if (repeat_more) begin
                    pass_nxt  = wrap_sat;
                    blend_nxt = 1'b1;
                  end else begin
                    active_nxt = 1'b0;
                  end
                end
              end
            end
            ett_pkg::OP_FINISH: begin
              delay_el_nxt = {1'b0, delay_len_r};
              pass_nxt     = {1'b0, dur_r};
              held_nxt     = end_r;
            end
            ett_pkg::OP_COMPLETE: begin
              delay_el_nxt       = {1'b0, delay_len_r};
              pass_nxt           = {1'b0, dur_r};
              held_nxt           = end_r;
              active_nxt         = 1'b0;
              flags_nxt.finished = 1'b1;
            end
            ett_pkg::OP_CANCEL: begin
              active_nxt         = 1'b0;
              flags_nxt.canceled = 1'b1;
            end
            default: begin
            end
          endcase
        end
        flags_nxt.running = active_nxt;
        state_nxt         = S_DSET;
      end

      // raw fraction: full when the pass reached its duration
      S_DSET: begin
        if (pass_r >= {1'b0, dur_r}) begin
          t_nxt     = ONE;
          state_nxt = S_EASE0;
        end else begin
          alu_cmd.op = ett_pkg::ALU_LOAD_DIV;
          cnt_nxt    = '0;
          state_nxt  = S_DIV;
        end
      end

      S_DIV: begin
        alu_cmd.op = ett_pkg::ALU_DIV_STEP;
        if (cnt_r == CNT_W'(F-1)) begin
          state_nxt = S_DEND;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      S_DEND: begin
        t_nxt     = {1'b0, alu_quo};
        state_nxt = S_EASE0;
      end

      // easing: first square
      S_EASE0: begin
        if (curve_sq) begin
          alu_cmd.op = ett_pkg::ALU_MUL;
          alu_ma     = {1'b0, t_r};
          alu_mb     = {1'b0, t_r};
          state_nxt  = S_EASE1;
        end else if (curve_r == ett_pkg::CURVE_QUAD_OUT) begin
          alu_cmd.op = ett_pkg::ALU_MUL;
          alu_ma     = {1'b0, ONE - t_r};
          alu_mb     = {1'b0, ONE - t_r};
          state_nxt  = S_EASE1;
        end else begin
          s_nxt     = t_r;
          state_nxt = S_BSET;
        end
      end

      S_EASE1: begin
        if (curve_smooth) begin
          alu_cmd.op = ett_pkg::ALU_MUL;
          alu_ma     = {1'b0, sq_hi};
          alu_mb     = ONE_X3 - {t_r, 1'b0};
          state_nxt  = S_EASE2;
        end else if (curve_r == ett_pkg::CURVE_QUAD_OUT) begin
          s_nxt     = ONE - sq_hi;
          state_nxt = S_BSET;
        end else begin
          s_nxt     = sq_hi;
          state_nxt = S_BSET;
        end
      end

      S_EASE2: begin
        s_nxt     = sq_hi;
        state_nxt = S_BSET;
      end

      // serial blend, most significant bit of the eased fraction first
      S_BSET: begin
        if (blend_r) begin
          alu_cmd.op = ett_pkg::ALU_CLEAR;
          cnt_nxt    = CNT_W'(F);
          state_nxt  = S_BLEND;
        end else begin
          state_nxt = S_OUT;
        end
      end

      S_BLEND: begin
        alu_cmd.op     = ett_pkg::ALU_BLEND_STEP;
        alu_cmd.bit_in = s_r[cnt_r];
        if (cnt_r == '0) begin
          state_nxt = S_BFIN;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end

      S_BFIN: begin
        held_nxt  = start_r + alu_acc[F+VALUE_BITS-1:F];
        state_nxt = S_OUT;
      end

      S_OUT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  assign res_value = held_r;
  assign res_frac  = s_r;
  assign res_flags = flags_r;

  // control and channel state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cnt_r      <= '0;
      active_r   <= 1'b0;
      begun_r    <= 1'b0;
      delay_el_r <= '0;
      pass_r     <= '0;
      passes_r   <= '0;
      held_r     <= '0;
      blend_r    <= 1'b0;
      flags_r    <= '0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      active_r   <= active_nxt;
      begun_r    <= begun_nxt;
      delay_el_r <= delay_el_nxt;
      pass_r     <= pass_nxt;
      passes_r   <= passes_nxt;
      held_r     <= held_nxt;
      blend_r    <= blend_nxt;
      flags_r    <= flags_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    op_r <= op_nxt;
    dt_r <= dt_nxt;
    t_r  <= t_nxt;
    s_r  <= s_nxt;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      curve_r     <= '0;
      delay_len_r <= '0;
      dur_r       <= '0;
      repeat_r    <= ett_pkg::COUNT_BITS'(1);
      start_r     <= '0;
      end_r       <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        ett_pkg::REG_CURVE:    curve_r     <= cfg_data[ett_pkg::CURVE_BITS-1:0];
        ett_pkg::REG_DELAY:    delay_len_r <= cfg_data[TIME_BITS-1:0];
        ett_pkg::REG_DURATION: dur_r       <= cfg_data[TIME_BITS-1:0];
        ett_pkg::REG_REPEAT:   repeat_r    <= cfg_data[ett_pkg::COUNT_BITS-1:0];
        ett_pkg::REG_START:    start_r     <= cfg_data[VALUE_BITS-1:0];
        ett_pkg::REG_END:      end_r       <= cfg_data[VALUE_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### sv/eased_tween_timeline.sv
// eased_tween_timeline: top level of one tween channel with easing curves.
// Instantiates ett_seq and ett_alu and holds the result register; uses ett_pkg.
//
//  channel | ports                         | direction | word
//  --------+-------------------------------+-----------+---------------------------------
//  in_     | tvalid tready tdata tuser     | slave     | tick length, command opcode
//  out_    | tvalid tready tdata tuser     | master    | value and eased fraction, flags
//  cfg_    | wr_en index data              | write     | curve, delay, duration, repeat,
//          |                               |           | start and end value
//
// From acceptance to its result being offered, a command runs through a FRACTION_BITS-step
// restoring division for the raw fraction (skipped at a full pass), up to two registered
// multiplies for the curve, and a FRACTION_BITS+1-step serial blend (only when blending), all on
// the one shared adder and multiplier in ett_alu. in_tready is high only while the
// sequencer is idle. Reset is synchronous, active low, and restores the configuration
// defaults. A result waits in the output register under out_tready low while the next
// command is accepted; the sequencer holds its own result only if that register is full.
`default_nettype none

module eased_tween_timeline #(
  parameter int TIME_BITS     = ett_pkg::TIME_BITS_DEF,
  parameter int VALUE_BITS    = ett_pkg::VALUE_BITS_DEF,
  parameter int FRACTION_BITS = ett_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst_n,
  input  wire logic                                      in_tvalid,
  output logic                                           in_tready,
  input  wire logic [ett_pkg::TICK_BITS-1:0]             in_tdata,   // [15:0] tick_length
  input  wire logic [ett_pkg::OPCODE_BITS-1:0]           in_tuser,   // [2:0] opcode
  output logic                                           out_tvalid,
  input  wire logic                                      out_tready,
  // current_value from bit 0, then eased_fraction, zero fill to whole bytes
  output logic [((VALUE_BITS+FRACTION_BITS+1+7)/8)*8-1:0] out_tdata,
  // started_event, finished_event, canceled_event, running from bit 0
  output logic [3:0]                                     out_tuser,
  input  wire logic                                      cfg_wr_en,
  input  wire logic [ett_pkg::CFG_INDEX_BITS-1:0]        cfg_index,
  input  wire logic [ett_pkg::max2(ett_pkg::max2(TIME_BITS, VALUE_BITS),
                                   ett_pkg::COUNT_BITS)-1:0] cfg_data
);

  localparam int OUT_W  = ((VALUE_BITS+FRACTION_BITS+1+7)/8)*8;
  localparam int ACC_W  = ett_pkg::max2(VALUE_BITS+FRACTION_BITS+2, TIME_BITS+2);
  localparam int PROD_W = 2*FRACTION_BITS+4;

  logic                         res_valid, res_ready;
  logic [VALUE_BITS-1:0]        res_value;
  logic [FRACTION_BITS:0]       res_frac;
  ett_pkg::flags_t              res_flags;

  ett_pkg::alu_cmd_t            alu_cmd;
  logic [TIME_BITS:0]           alu_num;
  logic [TIME_BITS-1:0]         alu_den;
  logic [VALUE_BITS:0]          alu_d;
  logic [FRACTION_BITS+1:0]     alu_ma, alu_mb;
  logic [ACC_W-1:0]             alu_acc;
  logic [FRACTION_BITS-1:0]     alu_quo;
  logic [PROD_W-1:0]            alu_prod;

  logic                         out_valid_r, out_valid_nxt;
  logic [VALUE_BITS-1:0]        out_value_r;
  logic [FRACTION_BITS:0]       out_frac_r;
  ett_pkg::flags_t              out_flags_r;

  ett_seq #(
    .TIME_BITS    (TIME_BITS),
    .VALUE_BITS   (VALUE_BITS),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_opcode (in_tuser),
    .in_tick   (in_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_value (res_value),
    .res_frac  (res_frac),
    .res_flags (res_flags),
    .alu_cmd   (alu_cmd),
    .alu_num   (alu_num),
    .alu_den   (alu_den),
    .alu_d     (alu_d),
    .alu_ma    (alu_ma),
    .alu_mb    (alu_mb),
    .alu_acc   (alu_acc),
    .alu_quo   (alu_quo),
    .alu_prod  (alu_prod)
  );

  ett_alu #(
    .TIME_BITS    (TIME_BITS),
    .VALUE_BITS   (VALUE_BITS),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_alu (
    .clk    (clk),
    .cmd    (alu_cmd),
    .div_num(alu_num),
    .div_den(alu_den),
    .blend_d(alu_d),
    .mul_a  (alu_ma),
    .mul_b  (alu_mb),
    .acc_o  (alu_acc),
    .quo_o  (alu_quo),
    .prod_o (alu_prod)
  );

  // output register: free when empty or being taken this cycle
  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_value_r <= res_value;
      out_frac_r  <= res_frac;
      out_flags_r <= res_flags;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({out_frac_r, out_value_r});
  assign out_tuser  = out_flags_r;

endmodule

`default_nettype wire

### sv/ett_checker.sv
// ett_checker: port-level checks of eased_tween_timeline, attached by the bind below.
// Depends on ett_pkg and on the top level's port list.
`default_nettype none

module ett_checker #(
  parameter int VALUE_BITS    = ett_pkg::VALUE_BITS_DEF,
  parameter int FRACTION_BITS = ett_pkg::FRACTION_BITS_DEF
) (
  input wire logic                                        clk,
  input wire logic                                        rst_n,
  input wire logic                                        in_tvalid,
  input wire logic                                        in_tready,
  input wire logic                                        out_tvalid,
  input wire logic                                        out_tready,
  input wire logic [((VALUE_BITS+FRACTION_BITS+1+7)/8)*8-1:0] out_tdata,
  input wire logic [3:0]                                  out_tuser
);

  localparam logic [FRACTION_BITS:0] ONE = {1'b1, {FRACTION_BITS{1'b0}}};

  ett_pkg::flags_t flags;
  assign flags = out_tuser;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed under stall");

  // a command keeps the sequencer busy for the next cycle
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("command accepted while busy");

  // eased fraction never passes one
  a_frac: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[VALUE_BITS+FRACTION_BITS:VALUE_BITS] <= ONE)
    else $error("eased fraction above one");

  // cancel stands alone and leaves the channel stopped
  a_cancel: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && flags.canceled |-> !flags.running && !flags.finished && !flags.started)
    else $error("cancel word with other flags");

  // a start comes from a tick on a running channel
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && flags.started |-> flags.running || flags.finished)
    else $error("start flag on a stopped channel");

endmodule

bind eased_tween_timeline ett_checker #(
  .VALUE_BITS   (VALUE_BITS),
  .FRACTION_BITS(FRACTION_BITS)
) u_ett_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);

`default_nettype wire
